/* rtl/core/tsds_pkg.sv */
// ============================================================================
// tsds_pkg
// Shared field widths, operation kinds and status codes of the two-stack
// deque store.
// ============================================================================
package tsds_pkg;

    // Field widths of the stream items.
    localparam int KIND_W     = 3;
    localparam int POS_W      = 9;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 10;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 48;

    typedef logic [KIND_W-1:0]   kind_t;
    typedef logic [STATUS_W-1:0] status_t;

    // Operation kinds carried on the input tuser.
    localparam kind_t KIND_PUSH_FRONT = 3'd0;
    localparam kind_t KIND_PUSH_BACK  = 3'd1;
    localparam kind_t KIND_READ_AT    = 3'd2;
    localparam kind_t KIND_WRITE_AT   = 3'd3;
    localparam kind_t KIND_READ_FRONT = 3'd4;
    localparam kind_t KIND_READ_BACK  = 3'd5;

    // Result status codes.
    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_RANGE = 2'd1;
    localparam status_t ST_FULL  = 2'd2;

endpackage

/* rtl/core/two_stack_deque_store.sv */
// ============================================================================
// two_stack_deque_store
// Double-ended store kept as two stacks in two RAMs, with push, indexed
// read and write, and front and back reads, every access bounds checked.
// ============================================================================
//
//  Channel   Direction  Signals                    Contents
//  --------  ---------  -------------------------  ---------------------------
//  s_axis    in         s_tvalid s_tready s_tdata  position, data_value
//                       s_tuser                    kind
//  m_axis    out        m_tvalid m_tready m_tdata  read_value, status,
//                                                  item_count, is_empty
//
// The block takes one item per clock cycle while the output is not stalled.
// Each item gives one result: the stack RAM read is issued at the edge that
// takes the item, into the stage 1 registers, and the read data then passes
// into the output register with the rest of the result. The counts are
// updated at the edge that takes the item, so the next item already sees
// them; each item touches at most one RAM entry, and a write always lands
// before any later read of that entry.
// Reset clears the two counts and the pipeline valid bits; the RAM contents
// are not cleared, since bounds checks only let written entries be read, so
// there is no clearing pass. When the output is stalled, the pipeline holds
// its result and the RAM read data, and the input stops being ready once
// both stages are full.
//
module two_stack_deque_store #(
    parameter int STACK_DEPTH = 256,
    parameter int DATA_WIDTH  = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Bits from low: position [8:0], data_value [40:9], zero fill [47:41].
    input  logic [tsds_pkg::IN_DATA_W-1:0]      s_tdata,
    // Bits from low: kind [2:0].
    input  logic [tsds_pkg::KIND_W-1:0]         s_tuser,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // Bits from low: read_value [31:0], status [33:32], item_count [43:34],
    // is_empty [44], zero fill [47:45].
    output logic [tsds_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    // Index width: wide enough for a position and for the total count.
    localparam int IW = (CW + 1 > tsds_pkg::POS_W) ? CW + 1 : tsds_pkg::POS_W;

    // ------------------------------------------------------------------
    // Input unpacking
    // ------------------------------------------------------------------
    tsds_pkg::kind_t                kind;
    logic [tsds_pkg::POS_W-1:0]     position;
    logic [tsds_pkg::VALUE_W-1:0]   data_value;
    logic [63:0]                    data_wide;
    logic [DATA_WIDTH-1:0]          store_data;

    assign kind       = s_tuser;
    assign position   = s_tdata[tsds_pkg::POS_W-1:0];
    assign data_value = s_tdata[tsds_pkg::POS_W +: tsds_pkg::VALUE_W];
    // Stored values are masked (or zero extended) to the storage width.
    assign data_wide  = 64'(data_value);
    assign store_data = data_wide[DATA_WIDTH-1:0];

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    logic [CW-1:0]             front_count_reg, front_count_next;
    logic [CW-1:0]             back_count_reg, back_count_next;

    // Stage 1: RAM read in flight.
    logic                      s1_valid_reg;
    logic                      s1_take_front_reg, s1_take_front_next;
    logic                      s1_take_back_reg, s1_take_back_next;
    tsds_pkg::status_t         s1_status_reg, s1_status_next;
    logic [CW:0]               s1_total_reg, s1_total_next;

    // Stage 2: output register.
    logic                      out_valid_reg;
    logic [tsds_pkg::VALUE_W-1:0] out_value_reg;
    tsds_pkg::status_t         out_status_reg;
    logic [tsds_pkg::COUNT_W-1:0] out_count_reg;

    logic                      in_fire;
    logic                      s1_advance;

    assign s1_advance = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready   = !s1_valid_reg || s1_advance;
    assign in_fire    = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Index resolution and operation decode
    // ------------------------------------------------------------------
    logic [CW:0]     total;
    logic [IW-1:0]   total_ix;
    logic [IW-1:0]   front_ix;
    logic [IW-1:0]   idx;
    logic            in_range;
    logic            hit_front;
    logic [AW-1:0]   front_slot;
    logic [AW-1:0]   back_slot;
    logic            front_full;
    logic            back_full;

    logic            front_wr_en, back_wr_en;
    logic [AW-1:0]   front_wr_addr, back_wr_addr;
    logic            front_rd_en, back_rd_en;
    logic [AW-1:0]   front_rd_addr, back_rd_addr;

    assign total      = {1'b0, front_count_reg} + {1'b0, back_count_reg};
    assign total_ix   = IW'(total);
    assign front_ix   = IW'(front_count_reg);
    assign front_full = (front_count_reg == CW'(STACK_DEPTH));
    assign back_full  = (back_count_reg == CW'(STACK_DEPTH));

    // Logical index for the indexed kinds; read back uses the last element.
    always_comb
    begin
        case (kind)
            tsds_pkg::KIND_READ_FRONT: idx = '0;
            tsds_pkg::KIND_READ_BACK:  idx = total_ix - IW'(1);
            default:                   idx = IW'(position);
        endcase
    end

    // An index below the front count reads the front stack in reverse order.
    assign in_range   = (total != '0) && (idx < total_ix);
    assign hit_front  = (idx < front_ix);
    assign front_slot = AW'(front_ix - idx - IW'(1));
    assign back_slot  = AW'(idx - front_ix);

    always_comb
    begin
        front_count_next   = front_count_reg;
        back_count_next    = back_count_reg;
        s1_take_front_next = 1'b0;
        s1_take_back_next  = 1'b0;
        s1_status_next     = tsds_pkg::ST_OK;
        front_wr_en        = 1'b0;
        back_wr_en         = 1'b0;
        front_wr_addr      = front_slot;
        back_wr_addr       = back_slot;
        front_rd_en        = 1'b0;
        back_rd_en         = 1'b0;
        front_rd_addr      = front_slot;
        back_rd_addr       = back_slot;

        case (kind)
            tsds_pkg::KIND_PUSH_FRONT:
            begin
                if (front_full)
                begin
                    s1_status_next = tsds_pkg::ST_FULL;
                end
                else
                begin
                    front_wr_en      = in_fire;
                    front_wr_addr    = AW'(front_count_reg);
                    front_count_next = front_count_reg + CW'(1);
                end
            end
            tsds_pkg::KIND_PUSH_BACK:
            begin
                if (back_full)
                begin
                    s1_status_next = tsds_pkg::ST_FULL;
                end
                else
                begin
                    back_wr_en      = in_fire;
                    back_wr_addr    = AW'(back_count_reg);
                    back_count_next = back_count_reg + CW'(1);
                end
            end
            tsds_pkg::KIND_WRITE_AT:
            begin
                if (!in_range)
                begin
                    s1_status_next = tsds_pkg::ST_RANGE;
                end
                else if (hit_front)
                begin
                    front_wr_en = in_fire;
                end
                else
                begin
                    back_wr_en = in_fire;
                end
            end
            tsds_pkg::KIND_READ_AT,
            tsds_pkg::KIND_READ_FRONT,
            tsds_pkg::KIND_READ_BACK:
            begin
                if (!in_range)
                begin
                    s1_status_next = tsds_pkg::ST_RANGE;
                end
                else if (hit_front)
                begin
                    front_rd_en        = in_fire;
                    s1_take_front_next = 1'b1;
                end
                else
                begin
                    back_rd_en        = in_fire;
                    s1_take_back_next = 1'b1;
                end
            end
            default:
            begin
                // Unknown kinds change nothing and report a range error.
                s1_status_next = tsds_pkg::ST_RANGE;
            end
        endcase
    end

    assign s1_total_next = {1'b0, front_count_next} + {1'b0, back_count_next};

    // ------------------------------------------------------------------
    // Stack memories
    // ------------------------------------------------------------------
    logic [DATA_WIDTH-1:0] front_rd_data;
    logic [DATA_WIDTH-1:0] back_rd_data;

    tsds_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (STACK_DEPTH)
    ) u_front_ram (
        .clk     (clk),
        .wr_en   (front_wr_en),
        .wr_addr (front_wr_addr),
        .wr_data (store_data),
        .rd_en   (front_rd_en),
        .rd_addr (front_rd_addr),
        .rd_data (front_rd_data)
    );

    tsds_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (STACK_DEPTH)
    ) u_back_ram (
        .clk     (clk),
        .wr_en   (back_wr_en),
        .wr_addr (back_wr_addr),
        .wr_data (store_data),
        .rd_en   (back_rd_en),
        .rd_addr (back_rd_addr),
        .rd_data (back_rd_data)
    );

    // ------------------------------------------------------------------
    // Result selection: zero unless a successful read took its RAM.
    // ------------------------------------------------------------------
    logic [63:0]                  sel_wide;
    logic [tsds_pkg::VALUE_W-1:0] sel_value;

    always_comb
    begin
        if (s1_take_front_reg)
        begin
            sel_wide = 64'(front_rd_data);
        end
        else if (s1_take_back_reg)
        begin
            sel_wide = 64'(back_rd_data);
        end
        else
        begin
            sel_wide = '0;
        end
    end

    assign sel_value = sel_wide[tsds_pkg::VALUE_W-1:0];

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_count_reg <= '0;
            back_count_reg  <= '0;
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                front_count_reg <= front_count_next;
                back_count_reg  <= back_count_next;
            end
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_take_front_reg <= s1_take_front_next;
            s1_take_back_reg  <= s1_take_back_next;
            s1_status_reg     <= s1_status_next;
            s1_total_reg      <= s1_total_next;
        end
        if (s1_advance)
        begin
            out_value_reg  <= sel_value;
            out_status_reg <= s1_status_reg;
            out_count_reg  <= tsds_pkg::COUNT_W'(s1_total_reg);
        end
    end

    // ------------------------------------------------------------------
    // Output packing
    // ------------------------------------------------------------------
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000,
                       (out_count_reg == '0),
                       out_count_reg,
                       out_status_reg,
                       out_value_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // The stack counts never pass the stack depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        (front_count_reg <= CW'(STACK_DEPTH)) && (back_count_reg <= CW'(STACK_DEPTH)))
    else $error("stack count exceeds depth");

    // A push onto a full front stack leaves the front count unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (kind == tsds_pkg::KIND_PUSH_FRONT) && front_full)
        |=> (front_count_reg == $past(front_count_reg)))
    else $error("refused push changed the front count");

    // A failed item always reports a zero read value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg != tsds_pkg::ST_OK)) |-> (out_value_reg == '0))
    else $error("failed item reports a nonzero value");

    // At most one RAM is read for any item.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> !(s1_take_front_reg && s1_take_back_reg))
    else $error("both stacks selected for one read");

endmodule

/* rtl/core/tsds_ram.sv */
// ============================================================================
// tsds_ram
// Generic single-clock RAM with one write port and one read port. The read
// data is registered and holds its value while no read is issued.
// ============================================================================
module tsds_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* tb/sv/tsds_checker.sv */
`timescale 1ns / 1ps
// ============================================================================
// tsds_checker
// Watches both streams of the two-stack deque store, predicts the result of
// every accepted item and compares each result field by field, in order.
// ============================================================================
module tsds_checker #(
    parameter int STACK_DEPTH = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Bits from low: position [8:0], data_value [40:9], zero fill [47:41].
    input  logic [tsds_pkg::IN_DATA_W-1:0]  s_tdata,
    // Bits from low: kind [2:0].
    input  logic [tsds_pkg::KIND_W-1:0]     s_tuser,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    // Bits from low: read_value [31:0], status [33:32], item_count [43:34],
    // is_empty [44], zero fill [47:45].
    input  logic [tsds_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    output int                              front_level,
    output int                              back_level,
    output int                              awaiting,
    output int                              fail_count
);

    typedef struct packed {
        logic [tsds_pkg::VALUE_W-1:0] read_value;
        tsds_pkg::status_t            status;
        logic [tsds_pkg::COUNT_W-1:0] item_count;
        logic                         is_empty;
    } deque_result_t;

    deque_result_t      awaited_results[$];

    // Shadow copy of the two stacks and their fill counts.
    logic [tsds_pkg::VALUE_W-1:0] front_mem [STACK_DEPTH];
    logic [tsds_pkg::VALUE_W-1:0] back_mem  [STACK_DEPTH];
    int                           front_used;
    int                           back_used;

    // Applies one item to the shadow deque and returns the result it gives.
    function automatic deque_result_t apply_deque_op(
        tsds_pkg::kind_t                kind,
        logic [tsds_pkg::POS_W-1:0]     pos,
        logic [tsds_pkg::VALUE_W-1:0]   val);
        deque_result_t res;
        int            total;
        int            idx;
        res        = '0;
        res.status = tsds_pkg::ST_OK;
        total      = front_used + back_used;
        case (kind)
            tsds_pkg::KIND_PUSH_FRONT:
            begin
                if (front_used >= STACK_DEPTH)
                    res.status = tsds_pkg::ST_FULL;
                else
                begin
                    front_mem[front_used] = val;
                    front_used++;
                end
            end
            tsds_pkg::KIND_PUSH_BACK:
            begin
                if (back_used >= STACK_DEPTH)
                    res.status = tsds_pkg::ST_FULL;
                else
                begin
                    back_mem[back_used] = val;
                    back_used++;
                end
            end
            tsds_pkg::KIND_READ_AT, tsds_pkg::KIND_WRITE_AT,
            tsds_pkg::KIND_READ_FRONT, tsds_pkg::KIND_READ_BACK:
            begin
                if (kind == tsds_pkg::KIND_READ_FRONT)
                    idx = 0;
                else if (kind == tsds_pkg::KIND_READ_BACK)
                    idx = total - 1;
                else
                    idx = int'(pos);
                if (total == 0 || idx >= total)
                    res.status = tsds_pkg::ST_RANGE;
                else if (kind == tsds_pkg::KIND_WRITE_AT)
                begin
                    // The front stack is stored bottom up, so logical order reverses it.
                    if (idx < front_used)
                        front_mem[front_used - 1 - idx] = val;
                    else
                        back_mem[idx - front_used] = val;
                end
                else if (idx < front_used)
                    res.read_value = front_mem[front_used - 1 - idx];
                else
                    res.read_value = back_mem[idx - front_used];
            end
            default:
                res.status = tsds_pkg::ST_RANGE;
        endcase
        total          = front_used + back_used;
        res.item_count = tsds_pkg::COUNT_W'(total);
        res.is_empty   = (total == 0);
        return res;
    endfunction

    function automatic int check_field(string name, longint unsigned want,
                                       longint unsigned got);
        if (want == got)
            return 0;
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
        return 1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        deque_result_t want;
        deque_result_t pred;
        int            errs;
        if (!rst_n)
        begin
            front_used = 0;
            back_used  = 0;
            awaited_results.delete();
            front_level <= 0;
            back_level  <= 0;
            awaiting    <= 0;
            fail_count  <= 0;
        end
        else
        begin
            errs = 0;
            // The prediction goes in first so that even a result given in the same cycle as its item would match.
            if (s_tvalid && s_tready)
            begin
                pred = apply_deque_op(s_tuser, s_tdata[tsds_pkg::POS_W-1:0],
                                      s_tdata[tsds_pkg::POS_W +: tsds_pkg::VALUE_W]);
                awaited_results = {awaited_results, pred};
            end
            if (m_tvalid && m_tready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("result 0x%0h arrived with no item waiting for it", m_tdata);
                    errs++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    errs += check_field("read_value", want.read_value,
                                        m_tdata[tsds_pkg::VALUE_W-1:0]);
                    errs += check_field("status", want.status,
                                        m_tdata[tsds_pkg::VALUE_W +: tsds_pkg::STATUS_W]);
                    errs += check_field("item_count", want.item_count,
                                        m_tdata[tsds_pkg::VALUE_W + tsds_pkg::STATUS_W
                                                +: tsds_pkg::COUNT_W]);
                    errs += check_field("is_empty", want.is_empty,
                                        m_tdata[tsds_pkg::VALUE_W + tsds_pkg::STATUS_W
                                                + tsds_pkg::COUNT_W]);
                end
            end
            front_level <= front_used;
            back_level  <= back_used;
            awaiting    <= awaited_results.size();
            fail_count  <= fail_count + errs;
        end
    end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Drives items into the two-stack deque store with random idling on both
// streams, and reports the verdict given by the checker beside the block.
// ============================================================================
//
// The run starts with a short directed part on an empty store: reads and
// writes with nothing stored, the two unused kinds, a few pushes to both
// ends, and indexed reads and writes on each side of the split between the
// stacks and just past the end. Random phases follow. The store can only
// grow, so the early phases push rarely and spend most items on indexed
// and end reads at small fill levels, one phase runs with no idling on
// either side, and then both stacks are filled to the top and pushed past
// it, so that the last phase works on a full store where every position
// up to 511 is a valid index.
//
module tb_top;

    localparam int STACK_DEPTH = 256;
    localparam int DATA_WIDTH  = 32;

    // Kinds that the block does not define; they must be refused as out of range.
    localparam tsds_pkg::kind_t KIND_SPARE_LO = 3'd6;
    localparam tsds_pkg::kind_t KIND_SPARE_HI = 3'd7;

    // Sender and receiver each idle in this many cycles of a hundred.
    localparam int IDLE_PCT = 26;

    logic                            clk      = 1'b0;
    logic                            rst_n    = 1'b0;
    // Bits from low: position [8:0], data_value [40:9], zero fill [47:41].
    logic [tsds_pkg::IN_DATA_W-1:0]  s_tdata  = '0;
    // Bits from low: kind [2:0].
    logic [tsds_pkg::KIND_W-1:0]     s_tuser  = '0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    // Bits from low: read_value [31:0], status [33:32], item_count [43:34],
    // is_empty [44], zero fill [47:45].
    logic [tsds_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;

    // Levels seen by the checker; they trail the item just accepted by one.
    int                    front_level;
    int                    back_level;
    int                    awaiting;
    int                    fail_count;

    // While set, neither side idles.
    logic                  calm = 1'b0;

    always #5 clk = ~clk;

    two_stack_deque_store #(
        .STACK_DEPTH (STACK_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    tsds_checker #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .m_tdata     (m_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .front_level (front_level),
        .back_level  (back_level),
        .awaiting    (awaiting),
        .fail_count  (fail_count)
    );

    // The receiver stalls at random, except during the calm phase.
    always @(posedge clk)
    begin
        m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Offers one item after a random number of idle cycles and returns at the
    // edge that accepts it. The valid is only lowered in cycles that idle, so
    // back-to-back items keep it high without a glitch.
    task automatic send_item(tsds_pkg::kind_t kind, logic [tsds_pkg::POS_W-1:0] pos,
                             logic [tsds_pkg::VALUE_W-1:0] val);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{(tsds_pkg::IN_DATA_W - tsds_pkg::POS_W - tsds_pkg::VALUE_W){1'b0}},
                     val, pos};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Stops sending and waits until every predicted result has come back.
    // The first edge lets the checker count the item accepted last.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (awaiting != 0)
            @(posedge clk);
    endtask

    // Data values lean on the all-zero and all-one extremes now and then.
    function automatic logic [tsds_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Indexes mostly land inside the store, with a fair share on the ends,
    // on both sides of the split between the stacks, and just past the end.
    function automatic logic [tsds_pkg::POS_W-1:0] pick_position();
        int total;
        int pick;
        total = front_level + back_level;
        if (total == 0)
            return tsds_pkg::POS_W'($urandom_range(0, 511));
        case ($urandom_range(0, 9))
            0:       pick = 0;
            1:       pick = (front_level > 0) ? front_level - 1 : 0;
            2:       pick = front_level;
            3:       pick = total - 1;
            // With the store full there is no index past the end, so take the last one.
            4:       pick = (total > 511) ? 511 : total;
            5:       pick = $urandom_range(0, 511);
            default: pick = $urandom_range(0, total - 1);
        endcase
        return tsds_pkg::POS_W'(pick);
    endfunction

    // Sends random items: a share of pushes, a share of raw noise over every
    // kind and position, and the rest indexed and end accesses.
    task automatic send_random(int count, int push_pct, int noise_pct);
        int              roll;
        tsds_pkg::kind_t kind;
        repeat (count)
        begin
            roll = $urandom_range(0, 99);
            if (roll < noise_pct)
                send_item(tsds_pkg::kind_t'($urandom_range(0, 7)),
                          tsds_pkg::POS_W'($urandom_range(0, 511)), $urandom);
            else if (roll < noise_pct + push_pct)
            begin
                kind = ($urandom_range(0, 1) == 0) ? tsds_pkg::KIND_PUSH_FRONT
                                                   : tsds_pkg::KIND_PUSH_BACK;
                send_item(kind, tsds_pkg::POS_W'($urandom_range(0, 511)), pick_value());
            end
            else
            begin
                case ($urandom_range(0, 5))
                    0, 1:    kind = tsds_pkg::KIND_READ_AT;
                    2, 3:    kind = tsds_pkg::KIND_WRITE_AT;
                    4:       kind = tsds_pkg::KIND_READ_FRONT;
                    default: kind = tsds_pkg::KIND_READ_BACK;
                endcase
                send_item(kind, pick_position(), pick_value());
            end
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every access to an empty store is out of range, as are the unused kinds.
        send_item(tsds_pkg::KIND_READ_FRONT, '0, '0);
        send_item(tsds_pkg::KIND_READ_BACK, '1, '1);
        send_item(tsds_pkg::KIND_READ_AT, '0, '0);
        send_item(tsds_pkg::KIND_WRITE_AT, '0, 32'hDEAD_BEEF);
        send_item(KIND_SPARE_LO, 9'h155, 32'h5555_5555);
        send_item(KIND_SPARE_HI, 9'h0AA, 32'hAAAA_AAAA);

        // Logical order after these pushes: 8000_0001, FFFF_FFFF, 0000_0000.
        send_item(tsds_pkg::KIND_PUSH_FRONT, '0, '1);
        send_item(tsds_pkg::KIND_PUSH_BACK, '1, '0);
        send_item(tsds_pkg::KIND_PUSH_FRONT, '0, 32'h8000_0001);
        send_item(tsds_pkg::KIND_READ_AT, 9'd0, '0);
        send_item(tsds_pkg::KIND_READ_AT, 9'd1, '0);
        send_item(tsds_pkg::KIND_READ_AT, 9'd2, '0);
        send_item(tsds_pkg::KIND_READ_AT, 9'd3, '0);
        send_item(tsds_pkg::KIND_READ_AT, '1, '0);

        // Writes to the back stack and to the bottom of the front stack, each
        // read back at once, and one write just past the end.
        send_item(tsds_pkg::KIND_WRITE_AT, 9'd2, 32'h1234_5678);
        send_item(tsds_pkg::KIND_READ_BACK, '0, '0);
        send_item(tsds_pkg::KIND_WRITE_AT, 9'd1, 32'h0F0F_0F0F);
        send_item(tsds_pkg::KIND_READ_AT, 9'd1, '0);
        send_item(tsds_pkg::KIND_WRITE_AT, 9'd3, '1);
        send_item(tsds_pkg::KIND_READ_FRONT, '0, '0);
        send_item(tsds_pkg::KIND_READ_AT, 9'd2, '0);

        // Low fill levels: mostly accesses, few pushes.
        send_random(500, 15, 10);

        // Hold the sender off until the block has emptied its pipeline.
        drain_results();

        // A long stretch with no idling on either side.
        calm <= 1'b1;
        send_random(300, 30, 10);
        calm <= 1'b0;

        send_random(400, 35, 10);

        // Fill both stacks to the top, then push past it to see the refusals.
        while (front_level < STACK_DEPTH)
            send_item(tsds_pkg::KIND_PUSH_FRONT, tsds_pkg::POS_W'($urandom_range(0, 511)),
                      pick_value());
        repeat (3)
            send_item(tsds_pkg::KIND_PUSH_FRONT, tsds_pkg::POS_W'($urandom_range(0, 511)),
                      pick_value());
        while (back_level < STACK_DEPTH)
            send_item(tsds_pkg::KIND_PUSH_BACK, tsds_pkg::POS_W'($urandom_range(0, 511)),
                      pick_value());
        repeat (3)
            send_item(tsds_pkg::KIND_PUSH_BACK, tsds_pkg::POS_W'($urandom_range(0, 511)),
                      pick_value());

        // Full store: every push is refused and all 512 positions are valid.
        send_random(200, 20, 10);

        drain_results();
        // A few more cycles catch any stray result.
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Guard against a hung handshake; a correct run ends far sooner.
    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
